/* sv/b64d_pkg.sv */
package b64d_pkg;

	// Width of the per-text byte counter; it saturates at all ones.
	localparam int COUNT_WIDTH = 16;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef enum logic [1:0] {
		ST_RUNNING   = 2'd0,
		ST_OK        = 2'd1,
		ST_UNEXP_END = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

	// Class of one text character.
	typedef struct packed {
		logic       skip;
		logic       pad;
		logic       invalid;
		logic [5:0] value;
	} sym_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        byte_valid;
		status_t     status;
		logic [15:0] bytes_so_far;
		logic        last_of_run;
	} result_t;

	// Results caused by one input item, oldest in entry zero.
	typedef struct packed {
		logic [1:0]        n;
		result_t [2:0]     res;
	} group_t;

	function automatic sym_t classify(input logic [7:0] ch);
		sym_t s;
		s = '0;
		unique case (ch) inside
			8'h20, 8'h0A, 8'h0D: s.skip = 1'b1;
			8'h3D:               s.pad = 1'b1;
			[8'h41:8'h5A]:       s.value = 6'(ch - 8'h41);
			[8'h61:8'h7A]:       s.value = 6'(ch - 8'h47);
			[8'h30:8'h39]:       s.value = 6'(ch + 8'h04);
			8'h2B:               s.value = 6'd62;
			8'h2F:               s.value = 6'd63;
			default:             s.invalid = 1'b1;
		endcase
		return s;
	endfunction

	function automatic count_t count_inc(input count_t c);
		return (c == '1) ? c : count_t'(c + count_t'(1));
	endfunction

	function automatic logic [15:0] count_out(input count_t c);
		logic [31:0] w;
		w = 32'(c);
		return w[15:0];
	endfunction

	function automatic logic count_hit(input count_t c, input logic [15:0] m);
		return 32'(c) == 32'(m);
	endfunction

endpackage

/* sv/b64d_in_if.sv */
interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       end_of_text;

	modport source (output valid, output text_char, output end_of_text, input ready);
	modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

/* sv/b64d_out_if.sv */
interface b64d_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic [1:0]  status;
	logic [15:0] bytes_so_far;
	logic        last_of_run;

	modport source (output valid, output data_byte, output byte_valid, output status,
		output bytes_so_far, output last_of_run, input ready);
	modport sink (input valid, input data_byte, input byte_valid, input status,
		input bytes_so_far, input last_of_run, output ready);
endinterface

/* sv/b64d_core.sv */
module b64d_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     max_bytes,
	b64d_in_if.sink         text_in,
	input  logic            buf_free,
	output logic            grp_load,
	output b64d_pkg::group_t grp
);
	import b64d_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	logic [1:0]  slot_q, slot_d;
	logic [17:0] acc_q, acc_d;
	logic        bad_q, bad_d;
	count_t      cnt_q, cnt_d;
	logic        halted_q, halted_d;
	status_t     fstat_q, fstat_d;

	sym_t        sym;
	logic        is_pad, is_bad, bad_n, complete, pad2, halt;
	logic [5:0]  code;
	logic [23:0] w;
	logic [1:0]  nout, nemit;
	count_t      c1, c2, c3;
	logic        h1, h2, h3;
	logic [7:0]  b0;
	status_t     st;
	logic        fire, accept;

	always_comb begin
		sym = classify(char_s1);
		is_pad = sym.pad && (slot_q >= 2'd2);
		is_bad = sym.invalid || (sym.pad && (slot_q < 2'd2));
		code = sym.value;
		bad_n = bad_q | is_bad;
		pad2 = is_pad && (slot_q == 2'd2);
		complete = pad2 || (slot_q == 2'd3);
		w = {acc_q, code};
		b0 = pad2 ? acc_q[11:4] : w[23:16];
		nout = pad2 ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
		c1 = count_inc(cnt_q);
		c2 = count_inc(c1);
		c3 = count_inc(c2);
		h1 = count_hit(c1, max_bytes);
		h2 = count_hit(c2, max_bytes);
		h3 = count_hit(c3, max_bytes);
		if (h1) begin
			nemit = 2'd1;
		end else if ((nout >= 2'd2) && h2) begin
			nemit = 2'd2;
		end else begin
			nemit = nout;
		end
		halt = (nemit != 2'd3) || h3;
		st = ST_RUNNING;

		slot_d = slot_q;
		acc_d = acc_q;
		bad_d = bad_q;
		cnt_d = cnt_q;
		halted_d = halted_q;
		fstat_d = fstat_q;
		grp = '0;

		if (end_s1) begin
			if (halted_q) begin
				st = fstat_q;
			end else if (slot_q == 2'd0) begin
				st = ST_OK;
			end else begin
				st = ST_UNEXP_END;
			end
			grp.n = 2'd1;
			grp.res[0] = '{data_byte: 8'd0, byte_valid: 1'b0, status: st,
				bytes_so_far: count_out(cnt_q), last_of_run: 1'b1};
			slot_d = '0;
			acc_d = '0;
			bad_d = 1'b0;
			cnt_d = '0;
			halted_d = 1'b0;
			fstat_d = ST_RUNNING;
		end else if (!halted_q && !sym.skip) begin
			if (!complete) begin
				acc_d = {acc_q[11:0], code};
				slot_d = slot_q + 2'd1;
				bad_d = bad_n;
			end else begin
				slot_d = '0;
				acc_d = '0;
				bad_d = 1'b0;
				halted_d = 1'b1;
				if (bad_n) begin
					fstat_d = ST_INVALID;
					grp.n = 2'd1;
					grp.res[0] = '{data_byte: 8'd0, byte_valid: 1'b0, status: ST_INVALID,
						bytes_so_far: count_out(cnt_q), last_of_run: 1'b1};
				end else begin
					halted_d = halt;
					if (halt) begin
						fstat_d = ST_OK;
						st = ST_OK;
					end
					grp.n = nemit;
					grp.res[0] = '{data_byte: b0, byte_valid: 1'b1, status: st,
						bytes_so_far: count_out(c1), last_of_run: (nemit == 2'd1)};
					grp.res[1] = '{data_byte: w[15:8], byte_valid: 1'b1, status: st,
						bytes_so_far: count_out(c2), last_of_run: (nemit == 2'd2)};
					grp.res[2] = '{data_byte: w[7:0], byte_valid: 1'b1, status: st,
						bytes_so_far: count_out(c3), last_of_run: 1'b1};
					if (nemit == 2'd1) begin
						cnt_d = c1;
					end else if (nemit == 2'd2) begin
						cnt_d = c2;
					end else begin
						cnt_d = c3;
					end
				end
			end
		end
	end

	// An item with results waits in stage one until the result buffer frees up.
	assign fire = valid_s1 && ((grp.n == 2'd0) || buf_free);
	assign grp_load = fire && (grp.n != 2'd0);
	assign text_in.ready = !valid_s1 || fire;
	assign accept = text_in.valid && text_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			slot_q <= '0;
			acc_q <= '0;
			bad_q <= 1'b0;
			cnt_q <= '0;
			halted_q <= 1'b0;
			fstat_q <= ST_RUNNING;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				slot_q <= slot_d;
				acc_q <= acc_d;
				bad_q <= bad_d;
				cnt_q <= cnt_d;
				halted_q <= halted_d;
				fstat_q <= fstat_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= text_in.text_char;
			end_s1 <= text_in.end_of_text;
		end
	end

endmodule

/* sv/b64d_rbuf.sv */
module b64d_rbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             grp_load,
	input  b64d_pkg::group_t grp,
	output logic             buf_free,
	b64d_out_if.source       result_out
);
	import b64d_pkg::*;

	result_t [2:0] ent_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign pop = (cnt_q != 2'd0) && result_out.ready;
	assign buf_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

	assign result_out.valid = (cnt_q != 2'd0);
	assign result_out.data_byte = ent_q[0].data_byte;
	assign result_out.byte_valid = ent_q[0].byte_valid;
	assign result_out.status = ent_q[0].status;
	assign result_out.bytes_so_far = ent_q[0].bytes_so_far;
	assign result_out.last_of_run = ent_q[0].last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (grp_load) begin
			cnt_q <= grp.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			ent_q <= grp.res;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

endmodule

/* sv/base64_decoder_whitespace_skip.sv */
// Base64 text decoder with whitespace skipping.
//
// The text_in channel takes one character per transaction, or an end item
// when end_of_text is set. The result_out channel gives the results of each
// item in order: decoded bytes, or a status result for an invalid quad and
// for the end of a text. last_of_run marks the final result of one item.
// The cfg_we/cfg_wdata port writes max_bytes, the byte limit of one text. The
// user writes it only while the block is idle; the block does not enforce it.
//
// An accepted item is registered in the input stage, is decoded there and
// its results are loaded into a three-entry result buffer. One item is
// accepted per cycle while the input stage does not stall. The result buffer
// sends one result per cycle while the receiver is ready, so an item that
// causes results stalls in the input stage while the buffer still holds
// results of an earlier item, for example an end item right after a quad
// that gave three bytes. When the receiver stalls, the buffer holds its
// results and text_in drops ready once such an item is waiting.
// Reset clears the decoder state and the buffer and sets max_bytes to 65535.
module base64_decoder_whitespace_skip (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	b64d_in_if.sink     text_in,
	b64d_out_if.source  result_out
);
	import b64d_pkg::*;

	logic [15:0] max_bytes_q;
	logic        buf_free;
	logic        grp_load;
	group_t      grp;

	// The byte limit register; zero is never reached and so means no limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= 16'hFFFF;
		end else if (cfg_we) begin
			max_bytes_q <= cfg_wdata;
		end
	end

	// Input stage with the decoder state and the per-item decode logic.
	b64d_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.max_bytes(max_bytes_q),
		.text_in  (text_in),
		.buf_free (buf_free),
		.grp_load (grp_load),
		.grp      (grp)
	);

	// Result buffer that serializes up to three results per item.
	b64d_rbuf u_rbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_load  (grp_load),
		.grp       (grp),
		.buf_free  (buf_free),
		.result_out(result_out)
	);

endmodule

/* sv/b64d_checker.sv */
module b64d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  data_byte,
	input logic        byte_valid,
	input logic [1:0]  status,
	input logic [15:0] bytes_so_far,
	input logic        last_of_run
);
	import b64d_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_status_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> last_of_run && (status != ST_RUNNING) && (data_byte == 8'd0))
		else $error("status result malformed");

	a_running_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_RUNNING) |-> byte_valid)
		else $error("running status on a result without a byte");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> bytes_so_far != 16'd0)
		else $error("byte emitted with zero count");

endmodule

bind base64_decoder_whitespace_skip b64d_checker u_b64d_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result_out.valid),
	.out_ready   (result_out.ready),
	.data_byte   (result_out.data_byte),
	.byte_valid  (result_out.byte_valid),
	.status      (result_out.status),
	.bytes_so_far(result_out.bytes_so_far),
	.last_of_run (result_out.last_of_run)
);

/* tb/testbench.sv */
// Self-checking bench for the base64 text decoder.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import b64d_pkg::*;

	// The 64 characters of the base64 alphabet, first character in the top byte.
	localparam logic [8*64-1:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// Length of the long receiver hold-off, in clock cycles.
	localparam int HOLD_CYCLES = 160;

	// Bound on the wait for outstanding results before a transaction is declared lost.
	localparam int DRAIN_GUARD = 20000;

	// Shapes of the random texts.
	typedef enum int {
		SHAPE_CLEAN,
		SHAPE_PADDED,
		SHAPE_TRUNCATED,
		SHAPE_CORRUPT,
		SHAPE_NOISE
	} text_shape_t;

	// Stall patterns of the result receiver.
	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_RHYTHM
	} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	b64d_in_if  text_if ();
	b64d_out_if result_if ();

	base64_decoder_whitespace_skip u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.text_in    (text_if),
		.result_out (result_if)
	);

	// The testbench's own copy of the decoder state and of the byte limit.
	logic [15:0] byte_limit;
	logic [1:0]  quad_fill;
	logic [17:0] sextets;
	logic        quad_bad;
	count_t      byte_count;
	logic        stopped;
	status_t     fin_status;

	// Results that the decoder owes us, oldest first.
	result_t pending_results[$];

	int failures;
	int decoded_items;     // Items that had an effect on the decoder.
	int burst_left;        // Items left in the current sender burst.
	logic sender_steady;   // When set, the sender offers items back to back.
	int hold_requests;     // Bumped by a test to ask the receiver for a long hold-off.

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// A generous fixed limit on the whole run; a hang lands here.
	initial begin
		#2_000_000;
		$display("base64_decoder_whitespace_skip verification failed");
		$finish;
	end

	function automatic logic [7:0] b64_char(input int v);
		return B64_ALPHABET[8*(63-v) +: 8];
	endfunction

	// Starts a fresh text. The byte limit is a register and keeps its value.
	function automatic void clear_text();
		quad_fill  = 2'd0;
		sextets    = '0;
		quad_bad   = 1'b0;
		byte_count = '0;
		stopped    = 1'b0;
		fin_status = ST_RUNNING;
	endfunction

	// Predicts the results of one accepted transaction and queues them.
	function automatic void decode_char(input logic [7:0] ch, input logic eot);
		result_t     run[$];
		result_t     r;
		logic [7:0]  out_bytes [3];
		logic [23:0] word;
		logic [5:0]  code;
		logic        is_pad;
		logic        known;
		int          n_bytes;
		status_t     st;

		r = '0;
		if (eot) begin
			// The end item reports the outcome and the count, then clears the text.
			decoded_items++;
			if (stopped)
				r.status = fin_status;
			else
				r.status = (quad_fill == 2'd0) ? ST_OK : ST_UNEXP_END;
			r.bytes_so_far = 16'(byte_count);
			r.last_of_run  = 1'b1;
			pending_results.push_back(r);
			clear_text();
			return;
		end

		// Once decoding has stopped, everything but the end item is dropped.
		if (stopped)
			return;
		// Whitespace never enters a quad.
		if (ch == " " || ch == 8'h0A || ch == 8'h0D)
			return;
		decoded_items++;

		is_pad = (ch == "=");
		known  = 1'b0;
		code   = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (b64_char(i) == ch) begin
				code  = 6'(i);
				known = 1'b1;
			end
		end
		// Padding is only legal in the last two slots; anywhere else, and any
		// character outside the alphabet, it marks the quad as bad with sextet zero.
		if (!known && !(is_pad && quad_fill >= 2'd2)) begin
			quad_bad = 1'b1;
			is_pad   = 1'b0;
		end

		n_bytes = 0;
		if (is_pad && quad_fill == 2'd2) begin
			// Padding in the third slot closes the quad with one byte.
			if (!quad_bad) begin
				out_bytes[0] = sextets[11:4];
				n_bytes = 1;
			end
		end else if (quad_fill != 2'd3) begin
			// The quad is not complete yet, so nothing comes out.
			sextets = {sextets[11:0], code};
			quad_fill++;
			return;
		end else if (!quad_bad) begin
			word = {sextets, is_pad ? 6'd0 : code};
			n_bytes = is_pad ? 2 : 3;
			out_bytes[0] = word[23:16];
			out_bytes[1] = word[15:8];
			out_bytes[2] = word[7:0];
		end

		if (quad_bad) begin
			// A bad quad gives a single status result and no bytes.
			stopped    = 1'b1;
			fin_status = ST_INVALID;
			r.bytes_so_far = 16'(byte_count);
			run.push_back(r);
		end else begin
			// A short quad means padding was seen, which ends the text cleanly.
			if (n_bytes < 3) begin
				stopped    = 1'b1;
				fin_status = ST_OK;
			end
			for (int i = 0; i < n_bytes; i++) begin
				if (byte_count != '1)
					byte_count++;
				r.data_byte    = out_bytes[i];
				r.byte_valid   = 1'b1;
				r.bytes_so_far = 16'(byte_count);
				run.push_back(r);
				// Reaching the limit drops the rest of the quad.
				if (32'(byte_count) == 32'(byte_limit)) begin
					stopped    = 1'b1;
					fin_status = ST_OK;
					break;
				end
			end
		end
		quad_fill = 2'd0;
		sextets   = '0;
		quad_bad  = 1'b0;

		// Every result of the transaction carries the status after it.
		st = stopped ? fin_status : ST_RUNNING;
		foreach (run[k]) begin
			run[k].status      = st;
			run[k].last_of_run = (k == run.size() - 1);
			pending_results.push_back(run[k]);
		end
	endfunction

	// Offers one item and returns once the decoder has taken it. Between bursts
	// of random length the sender sits out a random number of cycles, unless sender_steady is set.
	task automatic send_item(input logic [7:0] ch, input logic eot);
		int gap;

		gap = 0;
		if (!sender_steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
			burst_left--;
		end
		@(negedge clk);
		if (gap != 0) begin
			text_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_if.valid       <= 1'b1;
		text_if.text_char   <= ch;
		text_if.end_of_text <= eot;
		do
			@(posedge clk);
		while (text_if.ready !== 1'b1);
		decode_char(ch, eot);
	endtask

	task automatic send_chars(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	// The character of an end item is ignored, so it is random.
	task automatic send_end();
		send_item(8'($urandom), 1'b1);
	endtask

	// Sends one sextet character, sometimes after some whitespace. A spoiled
	// sextet is a random byte or padding, which usually makes the quad bad.
	task automatic send_sextet(input logic spoil);
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 2))
				0: send_item(" ", 1'b0);
				1: send_item(8'h0A, 1'b0);
				default: send_item(8'h0D, 1'b0);
			endcase
		end
		if (spoil)
			send_item(($urandom_range(0, 1) == 0) ? 8'h3D : 8'($urandom), 1'b0);
		else
			send_item(b64_char($urandom_range(0, 63)), 1'b0);
	endtask

	// Stops offering items and waits until every predicted result has arrived,
	// then lets a few cycles pass so that an item that causes no result has
	// left the input stage as well.
	task automatic settle_results();
		int guard;

		@(negedge clk);
		text_if.valid <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			failures++;
			pending_results.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// Writes max_bytes. Callers make sure the decoder is idle.
	task automatic write_byte_limit(input logic [15:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		byte_limit = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random text: mostly well-formed quads with random content, some
	// padded endings, some cut short, some with a bad character, some noise.
	task automatic send_random_text(input int max_quads);
		text_shape_t shape;
		int          pick;
		int          quads;
		int          pos;
		int          spoil_at;
		int          tail;

		pick = $urandom_range(0, 99);
		if (pick < 45)
			shape = SHAPE_CLEAN;
		else if (pick < 70)
			shape = SHAPE_PADDED;
		else if (pick < 80)
			shape = SHAPE_TRUNCATED;
		else if (pick < 90)
			shape = SHAPE_CORRUPT;
		else
			shape = SHAPE_NOISE;

		quads    = $urandom_range(0, max_quads);
		spoil_at = (shape == SHAPE_CORRUPT) ? $urandom_range(0, 4 * quads + 3) : -1;
		pos      = 0;

		if (shape == SHAPE_NOISE) begin
			repeat ($urandom_range(1, 12)) send_item(8'($urandom), 1'b0);
		end else begin
			repeat (4 * quads) begin
				send_sextet(pos == spoil_at);
				pos++;
			end
			case (shape)
				SHAPE_PADDED: begin
					tail = $urandom_range(2, 3);
					repeat (tail) begin
						send_sextet(1'b0);
					end
					repeat (4 - tail) send_item("=", 1'b0);
					// Anything after the padding is dropped until the end item.
					repeat ($urandom_range(0, 2)) send_item(8'($urandom), 1'b0);
				end
				SHAPE_TRUNCATED: begin
					repeat ($urandom_range(1, 3)) send_sextet(1'b0);
				end
				SHAPE_CORRUPT: begin
					repeat ($urandom_range(0, 3)) begin
						send_sextet(pos == spoil_at);
						pos++;
					end
				end
				default: begin
				end
			endcase
		end
		send_end();
	endtask

	// Hand-picked texts: full quads, padding in every slot, whitespace,
	// invalid characters at both ends of the byte range, items after a stop,
	// ends inside a quad and an empty text.
	task automatic test_directed_cases();
		// Three bytes, then two bytes with padding in the last slot, then an
		// ignored character after the stop.
		send_chars("TWFu/+9=");
		send_item("A", 1'b0);
		send_end();
		// A quad with invalid characters, with padding in the second slot and
		// whitespace between the slots, gives an invalid status.
		send_item(8'hFF, 1'b0);
		send_item("=", 1'b0);
		send_chars(" \r\n");
		send_item(8'h00, 1'b0);
		send_chars("\n/");
		send_end();
		// Padding in the third slot gives one byte.
		send_chars("AB=");
		send_end();
		// Padding in the first slot and an end after three sextets: unexpected end.
		send_chars("=WF");
		send_end();
		// An empty text finishes cleanly.
		send_end();
		settle_results();
	endtask

	// Small byte limits that stop decoding at every position within a quad.
	task automatic test_byte_limit();
		for (int lim = 1; lim <= 4; lim++) begin
			write_byte_limit(16'(lim));
			send_chars("TWFu////");
			send_end();
			settle_results();
		end
		write_byte_limit(16'hFFFF);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// back to back, so the result buffer fills and the input stalls. Then the
	// sender pauses mid-text until every result has come.
	task automatic test_backpressure();
		sender_steady = 1'b1;
		hold_requests++;
		repeat (10) begin
			repeat (4) send_item(b64_char($urandom_range(0, 63)), 1'b0);
		end
		sender_steady = 1'b0;
		settle_results();
		send_chars("QUJD");
		settle_results();
		send_chars("REVG");
		send_end();
		settle_results();
	endtask

	// Random texts under several byte limits, the extremes among them.
	task automatic test_random_texts();
		logic [15:0] limits [4];
		int          depth [4];
		int          goal;

		limits[0] = 16'hFFFF;
		limits[1] = 16'd1;
		limits[2] = 16'($urandom_range(2, 8));
		limits[3] = 16'($urandom_range(9, 30));
		depth[0]  = 4;
		depth[1]  = 3;
		depth[2]  = 6;
		depth[3]  = 10;
		for (int p = 0; p < 4; p++) begin
			write_byte_limit(limits[p]);
			goal = decoded_items + 25;
			while (decoded_items < goal)
				send_random_text(depth[p]);
			settle_results();
		end
	endtask

	// Result receiver. It changes its stall pattern at random intervals and
	// serves a long hold-off whenever a test asks for one.
	initial begin : result_receiver
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       hold_served;
		int       beat;

		mode        = RX_FREE;
		mode_left   = 0;
		hold_left   = 0;
		hold_served = 0;
		beat        = 0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_if.ready <= 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				beat++;
				case (mode)
					RX_FREE:   result_if.ready <= 1'b1;
					RX_COIN:   result_if.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: result_if.ready <= ($urandom_range(0, 4) == 0);
					default:   result_if.ready <= (beat % 3 != 0);
				endcase
			end
		end
	end

	// Every result transaction is compared with the oldest prediction.
	always @(posedge clk) begin : result_check
		result_t want;

		if (arst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no result expected");
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (result_if.data_byte !== want.data_byte) begin
					$error("data_byte: expected %0h, got %0h",
						want.data_byte, result_if.data_byte);
					failures++;
				end
				if (result_if.byte_valid !== want.byte_valid) begin
					$error("byte_valid: expected %0b, got %0b",
						want.byte_valid, result_if.byte_valid);
					failures++;
				end
				if (result_if.status !== 2'(want.status)) begin
					$error("status: expected %0d, got %0d", want.status, result_if.status);
					failures++;
				end
				if (result_if.bytes_so_far !== want.bytes_so_far) begin
					$error("bytes_so_far: expected %0d, got %0d",
						want.bytes_so_far, result_if.bytes_so_far);
					failures++;
				end
				if (result_if.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0b, got %0b",
						want.last_of_run, result_if.last_of_run);
					failures++;
				end
			end
		end
	end

	initial begin
		failures      = 0;
		decoded_items = 0;
		burst_left    = 0;
		sender_steady = 1'b0;
		hold_requests = 0;
		byte_limit    = 16'hFFFF;
		clear_text();

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		text_if.valid       = 1'b0;
		text_if.text_char   = '0;
		text_if.end_of_text = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_byte_limit();
		test_backpressure();
		test_random_texts();

		// Every expectation has been met by now; give the block a few more
		// cycles to show any stray result before the verdict.
		settle_results();
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("base64_decoder_whitespace_skip verification clean");
		else
			$display("base64_decoder_whitespace_skip verification failed");
		$finish;
	end

endmodule
